// ===== rtl/sapfm_pkg.sv =====
// Shared types and constants for the set-associative page-to-frame map.
// Used by the controller, the datapath and the top level.
`default_nettype none

package sapfm_pkg;

    localparam int ROW_BITS_DEF          = 8;
    localparam int ENTRIES_PER_CHUNK_DEF = 4;
    localparam int CHUNKS_PER_ROW_DEF    = 2;

    localparam int OP_W    = 2;
    localparam int PAGE_W  = 32;
    localparam int FRAME_W = 16;

    localparam logic [OP_W-1:0] OP_GET    = 2'd0;
    localparam logic [OP_W-1:0] OP_PUT    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [PAGE_W-1:0]  page_id;
        logic [FRAME_W-1:0] frame_value;
    } in_word_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_out;
        logic               full_res;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic clr_we;
        logic accept;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/sapfm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sapfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    clk,
    we,
    waddr,
    wdata,
    re,
    raddr,
    rdata
);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  wire logic              clk;
    input  wire logic              we;
    input  wire logic [ADDR_W-1:0] waddr;
    input  wire logic [WIDTH-1:0]  wdata;
    input  wire logic              re;
    input  wire logic [ADDR_W-1:0] raddr;
    output logic      [WIDTH-1:0]  rdata;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sapfm_ctrl.sv =====
// Controller for the page-to-frame map: clearing pass, accept, lookup.
// Depends on sapfm_pkg.
`default_nettype none

module sapfm_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire sapfm_pkg::ctrl_sts_t  sts,
    output sapfm_pkg::ctrl_cmd_t       cmd
);
    import sapfm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/sapfm_dp.sv =====
// Datapath for the page-to-frame map: row memory, tag compare, write-back, output word.
// Depends on sapfm_pkg and sapfm_ram.
`default_nettype none

module sapfm_dp #(
    parameter int ROW_BITS          = sapfm_pkg::ROW_BITS_DEF,
    parameter int ENTRIES_PER_CHUNK = sapfm_pkg::ENTRIES_PER_CHUNK_DEF,
    parameter int CHUNKS_PER_ROW    = sapfm_pkg::CHUNKS_PER_ROW_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sapfm_pkg::ctrl_cmd_t  cmd,
    output sapfm_pkg::ctrl_sts_t       sts,
    input  wire sapfm_pkg::in_word_t   in_data,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output sapfm_pkg::out_word_t       out_data
);
    import sapfm_pkg::*;

    localparam int ROWS      = 1 << ROW_BITS;
    localparam int WAYS      = ENTRIES_PER_CHUNK * CHUNKS_PER_ROW;
    localparam int TAG_W     = PAGE_W - ROW_BITS;
    localparam int WAY_W     = 1 + TAG_W + FRAME_W;
    localparam int ROW_W     = WAYS * WAY_W;
    localparam int WAY_IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    in_word_t            item_reg;
    out_word_t           out_reg;
    out_word_t           out_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [ROW_BITS-1:0] clr_cnt_reg;
    logic [ROW_BITS-1:0] clr_cnt_next;

    logic                ram_we;
    logic [ROW_BITS-1:0] ram_waddr;
    logic [ROW_W-1:0]    ram_wdata;
    logic [ROW_W-1:0]    ram_rdata;
    logic [ROW_W-1:0]    row_new;

    logic [WAY_W-1:0]    way_rd [WAYS];
    logic [WAY_W-1:0]    way_wr [WAYS];
    logic [WAYS-1:0]     match;
    logic [WAYS-1:0]     free;
    logic                any_match;
    logic                any_free;
    logic [WAY_IDX_W-1:0] match_idx;
    logic [WAY_IDX_W-1:0] free_idx;
    logic [TAG_W-1:0]    item_tag;
    logic [FRAME_W-1:0]  match_frame;

    assign item_tag = item_reg.page_id[PAGE_W-1:ROW_BITS];

    for (genvar g = 0; g < WAYS; g++)
    begin : g_way
        assign way_rd[g] = ram_rdata[g*WAY_W +: WAY_W];
        assign row_new[g*WAY_W +: WAY_W] = way_wr[g];
        assign match[g] = way_rd[g][WAY_W-1] && (way_rd[g][FRAME_W +: TAG_W] == item_tag);
        assign free[g]  = !way_rd[g][WAY_W-1];
    end

    assign any_match = |match;
    assign any_free  = |free;

    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                match_idx = WAY_IDX_W'(w);
            end
            if (free[w])
            begin
                free_idx = WAY_IDX_W'(w);
            end
        end
    end

    always_comb
    begin
        match_frame = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_IDX_W'(w) == match_idx)
            begin
                match_frame = way_rd[w][FRAME_W-1:0];
            end
        end
    end

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            way_wr[w] = way_rd[w];
            if (item_reg.operation == OP_PUT)
            begin
                if (any_match && (WAY_IDX_W'(w) == match_idx))
                begin
                    way_wr[w][FRAME_W-1:0] = item_reg.frame_value;
                end
                else if (!any_match && any_free && (WAY_IDX_W'(w) == free_idx))
                begin
                    way_wr[w] = {1'b1, item_tag, item_reg.frame_value};
                end
            end
            else if (item_reg.operation == OP_REMOVE)
            begin
                if (any_match && (WAY_IDX_W'(w) == match_idx))
                begin
                    way_wr[w][WAY_W-1] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        out_next = '0;
        if ((item_reg.operation == OP_GET) || (item_reg.operation == OP_PUT)
            || (item_reg.operation == OP_REMOVE))
        begin
            if (any_match)
            begin
                out_next.hit       = 1'b1;
                out_next.frame_out = match_frame;
            end
            else if (item_reg.operation == OP_PUT)
            begin
                out_next.full_res = !any_free;
            end
        end
    end

    assign ram_we    = cmd.clr_we || cmd.commit;
    assign ram_waddr = cmd.clr_we ? clr_cnt_reg : item_reg.page_id[ROW_BITS-1:0];
    assign ram_wdata = cmd.clr_we ? '0 : row_new;

    sapfm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.accept),
        .raddr (in_data.page_id[ROW_BITS-1:0]),
        .rdata (ram_rdata)
    );

    assign clr_cnt_next   = cmd.clr_we ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
    assign out_valid_next = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= in_data;
        end
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
    end

    assign sts.clr_last = &clr_cnt_reg;
    assign sts.out_busy = out_valid_reg && !out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_reg;

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("result word not presented after commit");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && !out_ready))
        else $error("result word overwritten while held");

    a_full_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.hit && out_reg.full_res))
        else $error("full flagged on a hit");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.hit |-> out_reg.frame_out == '0)
        else $error("non-zero frame on a miss");

endmodule

`default_nettype wire

// ===== rtl/set_assoc_page_frame_map.sv =====
// An accepted word's row is read from the row memory in IDLE; in LOOKUP, once the output is not stalled,
// the result word is registered and the row is written back. No new word is accepted until then.
// Each word costs one row read of the row memory and one write-back of that row.
// Reset: a clearing pass writes every row with in_ready low; result words are invalid during it.
// Depends on sapfm_pkg, sapfm_ctrl, sapfm_dp, sapfm_ram.
`default_nettype none

module set_assoc_page_frame_map #(
    parameter int ROW_BITS          = sapfm_pkg::ROW_BITS_DEF,
    parameter int ENTRIES_PER_CHUNK = sapfm_pkg::ENTRIES_PER_CHUNK_DEF,
    parameter int CHUNKS_PER_ROW    = sapfm_pkg::CHUNKS_PER_ROW_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire sapfm_pkg::in_word_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output sapfm_pkg::out_word_t      out_data
);
    import sapfm_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    sapfm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sapfm_dp #(
        .ROW_BITS          (ROW_BITS),
        .ENTRIES_PER_CHUNK (ENTRIES_PER_CHUNK),
        .CHUNKS_PER_ROW    (CHUNKS_PER_ROW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
